// ----- rtl/core/rac_pkg.sv -----
// Shared types and codes for the rational accumulator ALU.
package rac_pkg;

  // Action codes; six and seven are no-ops.
  localparam logic [2:0] ACT_LOAD = 3'd0;
  localparam logic [2:0] ACT_ADD  = 3'd1;
  localparam logic [2:0] ACT_SUB  = 3'd2;
  localparam logic [2:0] ACT_MUL  = 3'd3;
  localparam logic [2:0] ACT_DIV  = 3'd4;
  localparam logic [2:0] ACT_MAX  = 3'd5;

  // Status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_OVF  = 2'd2;

  // Width of the intermediate products and magnitudes.
  localparam int MAG_W = 64;
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_GCD,
    ST_DIV,
    ST_COMMIT,
    ST_OUT
  } rac_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul_en;
    logic prep;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic commit;
  } rac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_last;
    logic skip;
    logic gcd_done;
    logic div_done;
  } rac_stat_t;

endpackage

// ----- rtl/core/rational_accumulator_alu.sv -----
// Top level of the rational accumulator ALU.
//
//   channel | signals                                    | direction
//   input   | in_valid, in_stall, action, operand_*      | into block
//   output  | out_valid, out_stall, result_*, status     | out of block
//
// A beat that leaves the accumulator alone goes from the products straight to
// the output; otherwise it takes four products on one shared multiplier, up to
// 128 binary gcd steps on 64-bit magnitudes and 64 steps of the two bit-serial
// dividers. One beat is in flight at a time.
// Synchronous reset sets the accumulator to 1/1. A stalled result holds.
module rational_accumulator_alu
  import rac_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic signed [31:0] operand_num,
  input  logic signed [31:0] operand_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_num,
  output logic [30:0]        result_den,
  output logic [1:0]         status
);

  rac_cmd_t  cmd;
  rac_stat_t stat;

  // Sequencer.
  rac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and accumulator.
  rac_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .operand_num (operand_num),
    .operand_den (operand_den),
    .acc_num     (result_num),
    .acc_den     (result_den),
    .status      (status)
  );

`ifndef SYNTH
  // No new beat is taken while a result is pending.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // A result appears only after a capture has been made.
  a_out_after_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_stall) else $error("result without a beat");

  // The result holds while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(result_num) && $stable(status)))
    else $error("stalled result changed");
`endif

endmodule

// ----- rtl/core/rac_ctrl.sv -----
// Controller state machine for the rational accumulator ALU.
module rac_ctrl
  import rac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  rac_stat_t stat,
  output rac_cmd_t  cmd
);

  rac_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (stat.mul_last) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = stat.skip ? ST_OUT : ST_GCD;
      end
      ST_GCD: begin
        if (stat.gcd_done) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
      end
      ST_GCD: begin
        cmd.gcd_step  = !stat.gcd_done;
        cmd.div_start = stat.gcd_done;
      end
      ST_DIV: begin
        cmd.div_step = !stat.div_done;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/core/rac_datapath.sv -----
// Datapath: shared multiplier, binary gcd, two dividers and the accumulator.
module rac_datapath
  import rac_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  rac_cmd_t           cmd,
  output rac_stat_t          stat,
  input  logic [2:0]         action,
  input  logic signed [31:0] operand_num,
  input  logic signed [31:0] operand_den,
  output logic signed [31:0] acc_num,
  output logic [30:0]        acc_den,
  output logic [1:0]         status
);

  localparam logic [MAG_W-1:0] MAXPOS = (MAG_W'(1) << (WIDTH - 1)) - MAG_W'(1);

  logic [2:0]              act;
  logic signed [32:0]      on_r;
  logic signed [32:0]      od_r;
  logic                    od_zero;
  logic [1:0]              mul_idx;
  logic signed [MAG_W-1:0] p0, p1, p2, p3;
  logic                    neg;
  logic [MAG_W-1:0]        mn, md, ga, gb, g;
  logic [CNT_W-1:0]        gk;
  logic [MAG_W-1:0]        qn, qd;
  logic [MAG_W:0]          rn, rd;
  logic [CNT_W-1:0]        dcnt;

  // Capture the operand with its denominator made positive.
  logic signed [32:0] in_num_x, in_den_x;
  assign in_num_x = {operand_num[31], operand_num};
  assign in_den_x = {operand_den[31], operand_den};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act     <= action;
      od_zero <= (operand_den == 32'sd0);
      on_r    <= operand_den[31] ? -in_num_x : in_num_x;
      od_r    <= operand_den[31] ? -in_den_x : in_den_x;
    end
  end

  // One multiplier, four products in turn.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  always_comb begin
    ma = (mul_idx == 2'd0 || mul_idx == 2'd3) ? {acc_num[31], acc_num}
                                              : $signed({2'b00, acc_den});
    mb = (mul_idx == 2'd0 || mul_idx == 2'd2) ? od_r : on_r;
  end
  assign mprod = ma * mb;

  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      mul_idx <= '0;
    end else if (cmd.mul_en) begin
      mul_idx <= mul_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (mul_idx)
        2'd0:    p0 <= mprod[MAG_W-1:0];
        2'd1:    p1 <= mprod[MAG_W-1:0];
        2'd2:    p2 <= mprod[MAG_W-1:0];
        default: p3 <= mprod[MAG_W-1:0];
      endcase
    end
  end

  // Pick the raw fraction and find the cases that leave the accumulator alone.
  logic signed [MAG_W-1:0] pn, pd, on64, od64;
  logic                    skip;
  logic [1:0]              skip_code;
  always_comb begin
    on64      = {{(MAG_W-33){on_r[32]}}, on_r};
    od64      = {{(MAG_W-33){od_r[32]}}, od_r};
    pn        = on64;
    pd        = od64;
    skip      = 1'b0;
    skip_code = STATUS_OK;
    case (act)
      ACT_LOAD: begin
        pn = on64;
        pd = od64;
      end
      ACT_ADD: begin
        pn = p0 + p1;
        pd = p2;
      end
      ACT_SUB: begin
        pn = p0 - p1;
        pd = p2;
      end
      ACT_MUL: begin
        pn = p3;
        pd = p2;
      end
      ACT_DIV: begin
        pn = p0;
        pd = p1;
        if (on_r == 33'sd0) begin
          skip      = 1'b1;
          skip_code = STATUS_ZERO;
        end
      end
      ACT_MAX: begin
        if (!(p0 < p1)) skip = 1'b1;
      end
      default: begin
        skip = 1'b1;
      end
    endcase
    if (od_zero && act <= ACT_MAX) begin
      skip      = 1'b1;
      skip_code = STATUS_ZERO;
    end
  end

  // Binary gcd, one step a cycle; an odd pair drops one bit after subtracting.
  logic [MAG_W-1:0] gdiff_ab, gdiff_ba;
  assign gdiff_ab = ga - gb;
  assign gdiff_ba = gb - ga;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg <= (pn < 0) != (pd < 0);
      mn  <= (pn < 0) ? MAG_W'(-pn) : MAG_W'(pn);
      md  <= (pd < 0) ? MAG_W'(-pd) : MAG_W'(pd);
      ga  <= (pn < 0) ? MAG_W'(-pn) : MAG_W'(pn);
      gb  <= (pd < 0) ? MAG_W'(-pd) : MAG_W'(pd);
      gk  <= '0;
    end else if (cmd.gcd_step) begin
      if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        gk <= gk + CNT_W'(1);
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= gdiff_ab >> 1;
      end else begin
        gb <= gdiff_ba >> 1;
      end
    end
  end

  // Two restoring dividers that share the gcd as divisor.
  logic [MAG_W:0] rn_sh, rd_sh;
  assign rn_sh = {rn[MAG_W-1:0], qn[MAG_W-1]};
  assign rd_sh = {rd[MAG_W-1:0], qd[MAG_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      g    <= (ga | gb) << gk;
      qn   <= mn;
      qd   <= md;
      rn   <= '0;
      rd   <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (rn_sh >= {1'b0, g}) begin
        rn <= rn_sh - {1'b0, g};
        qn <= {qn[MAG_W-2:0], 1'b1};
      end else begin
        rn <= rn_sh;
        qn <= {qn[MAG_W-2:0], 1'b0};
      end
      if (rd_sh >= {1'b0, g}) begin
        rd <= rd_sh - {1'b0, g};
        qd <= {qd[MAG_W-2:0], 1'b1};
      end else begin
        rd <= rd_sh;
        qd <= {qd[MAG_W-2:0], 1'b0};
      end
      dcnt <= dcnt + CNT_W'(1);
    end
  end

  // Range check and write back.
  logic             neg_eff, ovf;
  logic [MAG_W-1:0] qn_neg;
  assign neg_eff = neg && (qn != '0);
  assign qn_neg  = '0 - qn;
  assign ovf     = (qd > MAXPOS) || (qn > MAXPOS + {{(MAG_W-1){1'b0}}, neg_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num <= 32'sd1;
      acc_den <= 31'd1;
      status  <= STATUS_OK;
    end else if (cmd.prep && skip) begin
      status <= skip_code;
    end else if (cmd.commit) begin
      status <= ovf ? STATUS_OVF : STATUS_OK;
      if (!ovf) begin
        acc_num <= neg_eff ? qn_neg[31:0] : qn[31:0];
        acc_den <= qd[30:0];
      end
    end
  end

  assign stat.mul_last = (mul_idx == 2'd3);
  assign stat.skip     = skip;
  assign stat.gcd_done = (ga == '0) || (gb == '0);
  assign stat.div_done = (dcnt == CNT_W'(MAG_W));

`ifndef SYNTH
  // The denominator is never zero.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    acc_den != 31'd0) else $error("accumulator denominator is zero");

  // The accumulator moves only on a commit.
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(cmd.commit) && !$past(rst)) |-> ($stable(acc_num) && $stable(acc_den)))
    else $error("accumulator changed without a commit");

  // A divide never starts before the gcd has settled.
  a_div_after_gcd: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> stat.gcd_done) else $error("divide started early");
`endif

endmodule
